/* rtl/character_lcd_nibble_interface_macros.svh */
// Assertion macros for the character LCD nibble interface RTL.
`ifndef CHARACTER_LCD_NIBBLE_INTERFACE_MACROS_SVH
`define CHARACTER_LCD_NIBBLE_INTERFACE_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define CLNIB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define CLNIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/clnib_pkg.sv */
// Types, constants and init tables for the character LCD nibble interface.
package clnib_pkg;

  // Request codes carried by each tick
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_DATA   = 2'd1,
    OP_CMD    = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  // Transfer sequencer phases
  typedef enum logic [2:0] {
    PH_POWER  = 3'd0,
    PH_SETUP  = 3'd1,
    PH_ENABLE = 3'd2,
    PH_HOLD   = 3'd3,
    PH_SETTLE = 3'd4,
    PH_EXTRA  = 3'd5,
    PH_IDLE   = 3'd6
  } phase_t;

  // Init sequence steps: 0..3 nibbles, 4..7 commands, 8 finished
  localparam logic [3:0] STEP_FIRST_CMD = 4'd4;
  localparam logic [3:0] STEP_CLEAR     = 4'd6;
  localparam logic [3:0] STEP_DONE      = 4'd8;

  // Set-cursor command pieces
  localparam logic [7:0] DDRAM_CMD = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'h40;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_BYTE_SETTLE = 3'd0;
  localparam cfg_idx_t REG_POWER_UP    = 3'd1;
  localparam cfg_idx_t REG_INIT_NIBBLE = 3'd2;
  localparam cfg_idx_t REG_CLEAR_EXTRA = 3'd3;
  localparam cfg_idx_t REG_PULSE_PHASE = 3'd4;

  // Reset values of the timing registers, in ticks
  localparam logic [15:0] BYTE_SETTLE_RST = 16'd2000;
  localparam logic [15:0] POWER_UP_RST    = 16'd50000;
  localparam logic [15:0] INIT_NIBBLE_RST = 16'd5000;
  localparam logic [15:0] CLEAR_EXTRA_RST = 16'd2000;
  localparam logic [7:0]  PULSE_PHASE_RST = 8'd1;

  typedef struct packed {
    logic [15:0] byte_settle_ticks;
    logic [15:0] power_up_ticks;
    logic [15:0] init_nibble_ticks;
    logic [15:0] clear_extra_ticks;
    logic [7:0]  pulse_phase_ticks;
  } cfg_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] byte_value;
    logic       cursor_row;
    logic [5:0] cursor_column;
  } req_t;

  // Wake-up nibbles 3, 3, 3, 2
  function automatic logic [3:0] init_nibble(input logic [1:0] idx);
    logic [3:0] val;
    case (idx)
      2'd3:    val = 4'h2;
      default: val = 4'h3;
    endcase
    return val;
  endfunction

  // Function set, display on, clear, entry mode
  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h28;
      2'd1:    val = 8'h0C;
      2'd2:    val = 8'h01;
      default: val = 8'h06;
    endcase
    return val;
  endfunction

endpackage

/* rtl/clnib_in_if.sv */
// Tick/request channel interface.
interface clnib_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       cursor_row;
  logic [5:0] cursor_column;

  modport source (output valid, operation, byte_value, cursor_row, cursor_column,
                  input ready);
  modport sink   (input valid, operation, byte_value, cursor_row, cursor_column,
                  output ready);
endinterface

/* rtl/clnib_out_if.sv */
// Pin-state result channel interface.
interface clnib_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_pins;
  logic       register_select;
  logic       enable_pin;
  logic       ready_res;
  logic       init_done;
  logic       request_dropped;

  modport source (output valid, data_pins, register_select, enable_pin, ready_res,
                  init_done, request_dropped, input ready);
  modport sink   (input valid, data_pins, register_select, enable_pin, ready_res,
                  init_done, request_dropped, output ready);
endinterface

/* rtl/clnib_cfg_if.sv */
// Configuration write channel interface.
interface clnib_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/clnib_cfg.sv */
// Timing configuration register file.
module clnib_cfg (
  input  logic            clk,
  input  logic            rst_n,
  clnib_cfg_if.sink       cfg,
  output clnib_pkg::cfg_t cfg_regs
);
  import clnib_pkg::*;

  cfg_t regs_r;
  cfg_t regs_nxt;

  // Always take a write beat
  assign cfg.ready = 1'b1;
  assign cfg_regs  = regs_r;

  // Decode the register index; indexes past the list are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_BYTE_SETTLE: regs_nxt.byte_settle_ticks = cfg.data;
        REG_POWER_UP:    regs_nxt.power_up_ticks    = cfg.data;
        REG_INIT_NIBBLE: regs_nxt.init_nibble_ticks = cfg.data;
        REG_CLEAR_EXTRA: regs_nxt.clear_extra_ticks = cfg.data;
        REG_PULSE_PHASE: regs_nxt.pulse_phase_ticks = cfg.data[7:0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.byte_settle_ticks <= BYTE_SETTLE_RST;
      regs_r.power_up_ticks    <= POWER_UP_RST;
      regs_r.init_nibble_ticks <= INIT_NIBBLE_RST;
      regs_r.clear_extra_ticks <= CLEAR_EXTRA_RST;
      regs_r.pulse_phase_ticks <= PULSE_PHASE_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

/* rtl/clnib_in_stage.sv */
// Input register for the tick/request channel.
module clnib_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  clnib_in_if.sink        in_ch,
  output logic            req_valid,
  output clnib_pkg::req_t req,
  input  logic            req_take
);
  import clnib_pkg::*;

  logic valid_r;
  logic valid_nxt;
  req_t req_r;
  logic in_beat;

  // Accept while empty or while the held beat moves on
  assign in_ch.ready = !valid_r || req_take;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign req_valid   = valid_r;
  assign req         = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_beat) begin
      valid_nxt = 1'b1;
    end else if (req_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_r.operation     <= op_t'(in_ch.operation);
      req_r.byte_value    <= in_ch.byte_value;
      req_r.cursor_row    <= in_ch.cursor_row;
      req_r.cursor_column <= in_ch.cursor_column;
    end
  end

endmodule

/* rtl/clnib_core.sv */
// Transfer sequencer: init sequence, nibble timing and result register.
`include "character_lcd_nibble_interface_macros.svh"

module clnib_core (
  input  logic            clk,
  input  logic            rst_n,
  input  clnib_pkg::cfg_t cfg_regs,
  input  logic            req_valid,
  input  clnib_pkg::req_t req,
  output logic            req_take,
  clnib_out_if.source     out_ch
);
  import clnib_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [7:0]  byte_latch_r, byte_latch_nxt;
  logic        low_half_r, low_half_nxt;
  logic [3:0]  init_step_r, init_step_nxt;
  logic [3:0]  pin_data_r, pin_data_nxt;
  logic        pin_rs_r, pin_rs_nxt;
  logic        pin_enable_r, pin_enable_nxt;

  logic        out_valid_r;
  logic [3:0]  out_data_r;
  logic        out_rs_r;
  logic        out_en_r;
  logic        out_rdy_r;
  logic        out_done_r;
  logic        out_drop_r;

  logic        fire;
  logic [15:0] limit;
  logic [15:0] wc_inc;
  logic        over;
  logic [3:0]  step_inc;
  logic [3:0]  init_sel;
  logic        init_is_nib;
  logic [7:0]  init_value;
  logic [7:0]  cursor_addr;
  logic        dropped;

  logic        start;
  logic [7:0]  start_value;
  logic        start_rs;
  logic        start_two;

  // Move one beat when the result register is empty or being taken
  assign req_take = !out_valid_r || out_ch.ready;
  assign fire     = req_valid && req_take;

  // Length of the current timed phase
  always_comb begin
    case (phase_r) inside
      PH_POWER:                     limit = cfg_regs.power_up_ticks;
      PH_SETUP, PH_ENABLE, PH_HOLD: limit = {8'd0, cfg_regs.pulse_phase_ticks};
      PH_SETTLE:                    limit = (init_step_r < STEP_FIRST_CMD) ?
                                            cfg_regs.init_nibble_ticks :
                                            cfg_regs.byte_settle_ticks;
      PH_EXTRA:                     limit = cfg_regs.clear_extra_ticks;
      default:                      limit = '1;
    endcase
  end

  // A zero limit or a wrapped count ends the phase at once
  assign wc_inc = wait_count_r + 16'd1;
  assign over   = (wc_inc >= limit) || (wc_inc == '0);

  // Next init item: current step on power-up, following step otherwise
  assign step_inc    = init_step_r + 4'd1;
  assign init_sel    = (phase_r == PH_POWER) ? init_step_r : step_inc;
  assign init_is_nib = init_sel < STEP_FIRST_CMD;
  assign init_value  = init_is_nib ? {4'd0, init_nibble(init_sel[1:0])} :
                                     init_cmd(init_sel[1:0]);

  // Row 1 starts at 0x40; the column never reaches that bit
  assign cursor_addr = DDRAM_CMD | (req.cursor_row ? ROW1_BASE : 8'd0) |
                       {2'd0, req.cursor_column};

  // Next state and result
  always_comb begin
    phase_nxt      = phase_r;
    wait_count_nxt = wait_count_r;
    byte_latch_nxt = byte_latch_r;
    low_half_nxt   = low_half_r;
    init_step_nxt  = init_step_r;
    pin_data_nxt   = pin_data_r;
    pin_rs_nxt     = pin_rs_r;
    pin_enable_nxt = pin_enable_r;
    dropped        = 1'b0;
    start          = 1'b0;
    start_value    = init_value;
    start_rs       = 1'b0;
    start_two      = !init_is_nib;

    if (phase_r != PH_IDLE) begin
      dropped = req.operation != OP_TICK;
    end

    unique case (phase_r)
      PH_IDLE: begin
        if (req.operation != OP_TICK) begin
          start     = 1'b1;
          start_two = 1'b1;
          case (req.operation)
            OP_DATA: begin
              start_value = req.byte_value;
              start_rs    = 1'b1;
            end
            OP_CMD:  start_value = req.byte_value;
            default: start_value = cursor_addr;
          endcase
        end
      end
      PH_POWER: begin
        wait_count_nxt = over ? 16'd0 : wc_inc;
        start          = over;
      end
      PH_SETUP: begin
        wait_count_nxt = over ? 16'd0 : wc_inc;
        if (over) begin
          phase_nxt      = PH_ENABLE;
          pin_enable_nxt = 1'b1;
        end
      end
      PH_ENABLE: begin
        wait_count_nxt = over ? 16'd0 : wc_inc;
        if (over) begin
          phase_nxt      = PH_HOLD;
          pin_enable_nxt = 1'b0;
        end
      end
      PH_HOLD: begin
        wait_count_nxt = over ? 16'd0 : wc_inc;
        if (over) begin
          if (low_half_r) begin
            low_half_nxt = 1'b0;
            pin_data_nxt = byte_latch_r[3:0];
            phase_nxt    = PH_SETUP;
          end else begin
            phase_nxt = PH_SETTLE;
          end
        end
      end
      PH_SETTLE, PH_EXTRA: begin
        wait_count_nxt = over ? 16'd0 : wc_inc;
        if (over) begin
          if (phase_r == PH_SETTLE && init_step_r == STEP_CLEAR &&
              cfg_regs.clear_extra_ticks != '0) begin
            phase_nxt = PH_EXTRA;
          end else if (init_step_r < STEP_DONE) begin
            init_step_nxt = step_inc;
            if (step_inc < STEP_DONE) begin
              start = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt      = PH_IDLE;
        wait_count_nxt = '0;
      end
    endcase

    // Load a new byte or init nibble into the sequencer
    if (start) begin
      byte_latch_nxt = start_value;
      low_half_nxt   = start_two;
      pin_data_nxt   = start_two ? start_value[7:4] : start_value[3:0];
      if (start_two) begin
        pin_rs_nxt = start_rs;
      end
      pin_enable_nxt = 1'b0;
      phase_nxt      = PH_SETUP;
      wait_count_nxt = '0;
    end
  end

  // Sequencer state advances one tick per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_POWER;
      wait_count_r <= '0;
      byte_latch_r <= '0;
      low_half_r   <= 1'b0;
      init_step_r  <= '0;
      pin_data_r   <= '0;
      pin_rs_r     <= 1'b0;
      pin_enable_r <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      wait_count_r <= wait_count_nxt;
      byte_latch_r <= byte_latch_nxt;
      low_half_r   <= low_half_nxt;
      init_step_r  <= init_step_nxt;
      pin_data_r   <= pin_data_nxt;
      pin_rs_r     <= pin_rs_nxt;
      pin_enable_r <= pin_enable_nxt;
    end
  end

  // Result valid: set on a beat, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload shows the state after the tick
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= pin_data_nxt;
      out_rs_r   <= pin_rs_nxt;
      out_en_r   <= pin_enable_nxt;
      out_rdy_r  <= phase_nxt == PH_IDLE;
      out_done_r <= init_step_nxt >= STEP_DONE;
      out_drop_r <= dropped;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.data_pins       = out_data_r;
  assign out_ch.register_select = out_rs_r;
  assign out_ch.enable_pin      = out_en_r;
  assign out_ch.ready_res       = out_rdy_r;
  assign out_ch.init_done       = out_done_r;
  assign out_ch.request_dropped = out_drop_r;

  `CLNIB_ASSERT_ALWAYS(a_enable_in_phase, clk, rst_n, pin_enable_r == (phase_r == PH_ENABLE), "E high outside the enable phase")
  `CLNIB_ASSERT_ALWAYS(a_step_range, clk, rst_n, init_step_r <= STEP_DONE, "init step past done")
  `CLNIB_ASSERT_ALWAYS(a_low_half_phase, clk, rst_n, !low_half_r || phase_r == PH_SETUP || phase_r == PH_ENABLE || phase_r == PH_HOLD, "low nibble pending outside a pulse")
  `CLNIB_ASSERT_NEXT(a_request_starts, clk, rst_n, fire && phase_r == PH_IDLE && req.operation != OP_TICK, phase_r == PH_SETUP, "request from idle did not start a transfer")

endmodule

/* rtl/character_lcd_nibble_interface.sv */
// A tick's result passes through the input register and then the result register.
// Throughput: one tick per cycle; the input register and the result register each
// take a new beat while the next stage takes theirs, so stalls only come from out_chan.
// Reset (rst_n low, synchronous) restores the timing registers and starts the
// power-up wait; requests are dropped until init_done rises.
// Top level of the character LCD nibble interface.
module character_lcd_nibble_interface (
  input  logic        clk,
  input  logic        rst_n,
  clnib_in_if.sink    in_chan,
  clnib_out_if.source out_chan,
  clnib_cfg_if.sink   cfg_chan
);
  import clnib_pkg::*;

  cfg_t cfg_regs;
  req_t req;
  logic req_valid;
  logic req_take;

  // Timing registers
  clnib_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_chan),
    .cfg_regs (cfg_regs)
  );

  // Input register
  clnib_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  // Sequencer and result register
  clnib_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_regs  (cfg_regs),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .out_ch    (out_chan)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the character LCD nibble interface: pin states against a tick model.
module tb_top;
  import clnib_pkg::*;

  // Cycles without any accepted beat before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // Index that selects no timing register
  localparam cfg_idx_t REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [3:0] data_pins;
    logic       register_select;
    logic       enable_pin;
    logic       ready_res;
    logic       init_done;
    logic       request_dropped;
  } lcd_pins_t;

  logic clk;
  logic rst_n;

  clnib_in_if  in_if();
  clnib_out_if out_if();
  clnib_cfg_if cfg_if();

  character_lcd_nibble_interface dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Tick model state and its copy of the timing registers
  phase_t      lcd_phase;
  logic [15:0] lcd_count;
  logic [7:0]  lcd_byte;
  logic        lcd_low_pending;
  logic [3:0]  lcd_step;
  logic [3:0]  lcd_data;
  logic        lcd_rs;
  logic        lcd_en;
  logic [15:0] t_settle;
  logic [15:0] t_power;
  logic [15:0] t_nibble;
  logic [15:0] t_clear;
  logic [7:0]  t_pulse;

  lcd_pins_t pins_due[$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tick model
  // ---------------------------------------------------------------------------

  function automatic void reset_lcd_model();
    t_settle        = BYTE_SETTLE_RST;
    t_power         = POWER_UP_RST;
    t_nibble        = INIT_NIBBLE_RST;
    t_clear         = CLEAR_EXTRA_RST;
    t_pulse         = PULSE_PHASE_RST;
    lcd_phase       = PH_POWER;
    lcd_count       = 16'd0;
    lcd_byte        = 8'h00;
    lcd_low_pending = 1'b0;
    lcd_step        = 4'd0;
    lcd_data        = 4'h0;
    lcd_rs          = 1'b0;
    lcd_en          = 1'b0;
  endfunction

  // Wake-up nibbles 3, 3, 3, then 2 to enter 4-bit mode
  function automatic logic [3:0] wake_nibble(input logic [3:0] step);
    return (step == 4'd3) ? 4'h2 : 4'h3;
  endfunction

  // Function set, display on, clear, entry mode
  function automatic logic [7:0] setup_command(input logic [3:0] step);
    logic [7:0] cmd;
    case (step - STEP_FIRST_CMD)
      4'd0:    cmd = 8'h28;
      4'd1:    cmd = 8'h0C;
      4'd2:    cmd = 8'h01;
      default: cmd = 8'h06;
    endcase
    return cmd;
  endfunction

  function automatic void start_byte(input logic [7:0] value, input logic rs);
    lcd_byte        = value;
    lcd_low_pending = 1'b1;
    lcd_rs          = rs;
    lcd_data        = value[7:4];
    lcd_en          = 1'b0;
    lcd_phase       = PH_SETUP;
    lcd_count       = 16'd0;
  endfunction

  function automatic void start_init_step();
    if (lcd_step < STEP_FIRST_CMD) begin
      lcd_byte        = {4'h0, wake_nibble(lcd_step)};
      lcd_low_pending = 1'b0;
      lcd_data        = lcd_byte[3:0];
      lcd_en          = 1'b0;
      lcd_phase       = PH_SETUP;
      lcd_count       = 16'd0;
    end else begin
      start_byte(setup_command(lcd_step), 1'b0);
    end
  endfunction

  function automatic void close_transfer();
    if (lcd_step < STEP_DONE) begin
      lcd_step = lcd_step + 4'd1;
      if (lcd_step < STEP_DONE) begin
        start_init_step();
        return;
      end
    end
    lcd_phase = PH_IDLE;
    lcd_count = 16'd0;
  endfunction

  // Count one tick; a zero limit ends the phase at once, a wrapped count too
  function automatic logic phase_elapsed(input logic [15:0] lim);
    lcd_count = lcd_count + 16'd1;
    if (lcd_count >= lim || lcd_count == 16'd0) begin
      lcd_count = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_lcd();
    case (lcd_phase)
      PH_POWER: begin
        if (phase_elapsed(t_power)) start_init_step();
      end
      PH_SETUP: begin
        if (phase_elapsed({8'h00, t_pulse})) begin
          lcd_phase = PH_ENABLE;
          lcd_en    = 1'b1;
        end
      end
      PH_ENABLE: begin
        if (phase_elapsed({8'h00, t_pulse})) begin
          lcd_phase = PH_HOLD;
          lcd_en    = 1'b0;
        end
      end
      PH_HOLD: begin
        if (phase_elapsed({8'h00, t_pulse})) begin
          if (lcd_low_pending) begin
            lcd_low_pending = 1'b0;
            lcd_data        = lcd_byte[3:0];
            lcd_phase       = PH_SETUP;
          end else begin
            lcd_phase = PH_SETTLE;
          end
        end
      end
      PH_SETTLE: begin
        if (phase_elapsed(lcd_step < STEP_FIRST_CMD ? t_nibble : t_settle)) begin
          if (lcd_step == STEP_CLEAR && t_clear != 16'd0) lcd_phase = PH_EXTRA;
          else close_transfer();
        end
      end
      PH_EXTRA: begin
        if (phase_elapsed(t_clear)) close_transfer();
      end
      default: begin
        lcd_phase = PH_IDLE;
        lcd_count = 16'd0;
      end
    endcase
  endfunction

  // Apply one tick and return the pin levels it leaves behind
  function automatic lcd_pins_t predict_pins(input op_t op, input logic [7:0] bv,
                                             input logic row, input logic [5:0] col);
    lcd_pins_t  p;
    logic [7:0] addr;
    p.request_dropped = 1'b0;
    addr = row ? (ROW1_BASE + {2'b00, col}) : {2'b00, col};
    if (lcd_phase == PH_IDLE) begin
      case (op)
        OP_DATA:   start_byte(bv, 1'b1);
        OP_CMD:    start_byte(bv, 1'b0);
        OP_CURSOR: start_byte(DDRAM_CMD | addr, 1'b0);
        default:   ;
      endcase
    end else begin
      p.request_dropped = (op != OP_TICK);
      advance_lcd();
    end
    p.data_pins       = lcd_data;
    p.register_select = lcd_rs;
    p.enable_pin      = lcd_en;
    p.ready_res       = (lcd_phase == PH_IDLE);
    p.init_done       = (lcd_step >= STEP_DONE);
    return p;
  endfunction

  function automatic void apply_timing(input cfg_idx_t idx, input logic [15:0] val);
    case (idx)
      REG_BYTE_SETTLE: t_settle = val;
      REG_POWER_UP:    t_power  = val;
      REG_INIT_NIBBLE: t_nibble = val;
      REG_CLEAR_EXTRA: t_clear  = val;
      REG_PULSE_PHASE: t_pulse  = val[7:0];
      default:         ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one tick beat, with random idle cycles in front of it
  task automatic send_tick(input op_t op, input logic [7:0] bv, input logic row,
                           input logic [5:0] col);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.byte_value    <= bv;
    in_if.cursor_row    <= row;
    in_if.cursor_column <= col;
    do @(posedge clk); while (!in_if.ready);
    pins_due.push_back(predict_pins(op, bv, row, col));
    beats_sent++;
  endtask

  // Mostly plain ticks, now and then a request, dropped if the sequencer is busy
  task automatic send_busy_beat();
    if ($urandom_range(9) == 0)
      send_tick(op_t'($urandom_range(3, 1)), 8'($urandom_range(255)),
                1'($urandom_range(1)), 6'($urandom_range(63)));
    else
      send_tick(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                6'($urandom_range(63)));
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_busy_beat();
  endtask

  task automatic run_to_phase(input phase_t target, input int max_beats);
    int n;
    n = 0;
    while (lcd_phase != target && n < max_beats) begin
      send_busy_beat();
      n++;
    end
  endtask

  // Drop valid and hold until every pin state has come back
  task automatic drain_pins();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timing(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    apply_timing(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // Receiver: stall at random, changing ready on the falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    lcd_pins_t want;
    if (out_if.valid && out_if.ready) begin
      if (pins_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat expected none actual data %h", $time,
                 out_if.data_pins);
      end else begin
        want = pins_due.pop_front();
        check_field("data_pins", int'(want.data_pins), int'(out_if.data_pins));
        check_field("register_select", int'(want.register_select),
                    int'(out_if.register_select));
        check_field("enable_pin", int'(want.enable_pin), int'(out_if.enable_pin));
        check_field("ready_res", int'(want.ready_res), int'(out_if.ready_res));
        check_field("init_done", int'(want.init_done), int'(out_if.init_done));
        check_field("request_dropped", int'(want.request_dropped),
                    int'(out_if.request_dropped));
      end
    end
  end

  // Abandon the run when no channel moves a beat for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Requests of every kind during the power-up wait must all be dropped
  task automatic test_power_up_drops();
    send_tick(OP_DATA, 8'hFF, 1'b1, 6'h3F);
    send_tick(OP_CMD, 8'h00, 1'b0, 6'h00);
    send_tick(OP_CURSOR, 8'h00, 1'b1, 6'h3F);
    send_tick(OP_CURSOR, 8'hFF, 1'b0, 6'h00);
    send_tick(OP_TICK, 8'hFF, 1'b1, 6'h3F);
    run_ticks(120);
  endtask

  // Shorten the init waits on the fly, stretching and cutting the clear wait
  task automatic test_init_sequence();
    drain_pins();
    write_timing(REG_POWER_UP, 16'hFFFF);
    write_timing(REG_INIT_NIBBLE, 16'hFFFF);
    run_ticks(20);
    drain_pins();
    // count already past the new limit: the wait ends on the next tick
    write_timing(REG_POWER_UP, 16'd1);
    write_timing(REG_INIT_NIBBLE, 16'd0);
    write_timing(REG_BYTE_SETTLE, 16'd2);
    run_to_phase(PH_EXTRA, 400);
    run_ticks(20);
    drain_pins();
    write_timing(REG_CLEAR_EXTRA, 16'hFFFF);
    run_ticks(20);
    drain_pins();
    write_timing(REG_CLEAR_EXTRA, 16'd7);
    run_to_phase(PH_IDLE, 400);
  endtask

  // Each request kind at the extremes of its fields, with a drop while busy
  task automatic test_each_request();
    drain_pins();
    write_timing(REG_BYTE_SETTLE, 16'd1);
    write_timing(REG_PULSE_PHASE, 16'd1);
    send_tick(OP_TICK, 8'h00, 1'b0, 6'h00);
    send_tick(OP_DATA, 8'h00, 1'b0, 6'h00);
    send_tick(OP_CMD, 8'hFF, 1'b1, 6'h3F);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_DATA, 8'hFF, 1'b1, 6'h3F);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_CMD, 8'h00, 1'b0, 6'h00);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_CMD, 8'hFF, 1'b0, 6'h00);
    send_tick(OP_CURSOR, 8'h00, 1'b1, 6'h3F);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_CURSOR, 8'hFF, 1'b0, 6'h00);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_CURSOR, 8'h00, 1'b1, 6'h3F);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_CURSOR, 8'h00, 1'b0, 6'h3F);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_CURSOR, 8'hFF, 1'b1, 6'h00);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_DATA, 8'hA5, 1'b0, 6'h15);
    run_to_phase(PH_IDLE, 50);
    send_tick(OP_CMD, 8'h5A, 1'b1, 6'h2A);
    run_to_phase(PH_IDLE, 50);
  endtask

  // Longest and shortest phase lengths, and lengths cut while a phase runs
  task automatic test_timing_extremes();
    drain_pins();
    write_timing(REG_BYTE_SETTLE, 16'hFFFF);
    write_timing(REG_PULSE_PHASE, 16'h00FF);
    send_tick(OP_DATA, 8'hC3, 1'b0, 6'h00);
    run_to_phase(PH_ENABLE, 400);
    run_ticks(10);
    drain_pins();
    // cut the longest pulse short once the enable phase has begun
    write_timing(REG_PULSE_PHASE, 16'd1);
    run_to_phase(PH_SETTLE, 50);
    run_ticks(30);
    drain_pins();
    write_timing(REG_BYTE_SETTLE, 16'd5);
    run_to_phase(PH_IDLE, 50);
    drain_pins();
    // zero lengths behave as one; upper data bits of the pulse write are ignored
    write_timing(REG_BYTE_SETTLE, 16'd0);
    write_timing(REG_PULSE_PHASE, 16'hAB00);
    write_timing(REG_UNUSED, 16'hFFFF);
    send_tick(OP_CMD, 8'h3C, 1'b1, 6'h11);
    run_to_phase(PH_IDLE, 50);
    drain_pins();
    write_timing(REG_PULSE_PHASE, 16'd20);
    send_tick(OP_CURSOR, 8'h00, 1'b1, 6'h27);
    run_to_phase(PH_ENABLE, 400);
    run_ticks(10);
    drain_pins();
    write_timing(REG_PULSE_PHASE, 16'h5503);
    run_to_phase(PH_IDLE, 100);
  endtask

  // Random requests whenever idle, ticks and stray requests while busy
  task automatic test_random_traffic(input int n_beats);
    int stop_at;
    drain_pins();
    write_timing(REG_BYTE_SETTLE, 16'($urandom_range(30)));
    write_timing(REG_PULSE_PHASE, 16'($urandom_range(3)));
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if (lcd_phase == PH_IDLE && $urandom_range(3) != 0)
        send_tick(op_t'($urandom_range(3, 1)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 6'($urandom_range(63)));
      else
        send_busy_beat();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.operation     = OP_TICK;
    in_if.byte_value    = 8'h00;
    in_if.cursor_row    = 1'b0;
    in_if.cursor_column = 6'h00;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_BYTE_SETTLE;
    cfg_if.data         = 16'h0000;
    reset_lcd_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(25, 61);
    test_power_up_drops();
    test_init_sequence();
    test_each_request();
    test_timing_extremes();
    test_random_traffic(190);
    set_idling(61, 25);
    test_random_traffic(190);
    set_idling(0, 0);
    test_random_traffic(190);

    drain_pins();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
